FILE: sv/bpsd_pkg.sv
package bpsd_pkg;

   localparam int ADDR_BITS = 24;

   typedef enum logic [3:0] {
      PH_MAGIC   = 4'd0,
      PH_SRC     = 4'd1,
      PH_TGT     = 4'd2,
      PH_METALEN = 4'd3,
      PH_META    = 4'd4,
      PH_CMD     = 4'd5,
      PH_LIT     = 4'd6,
      PH_OFS     = 4'd7,
      PH_TRAILER = 4'd8,
      PH_DONE    = 4'd9,
      PH_ERROR   = 4'd10
   } phase_type;

   typedef enum logic [2:0] {
      KIND_LITERAL  = 3'd0,
      KIND_SRC_READ = 3'd1,
      KIND_SRC_COPY = 3'd2,
      KIND_TGT_COPY = 3'd3,
      KIND_DONE     = 3'd4,
      KIND_ERROR    = 3'd5
   } kind_type;

   localparam logic [1:0] ERR_MALFORMED = 2'd0;
   localparam logic [1:0] ERR_SIZE      = 2'd1;
   localparam logic [1:0] ERR_RANGE     = 2'd2;

   localparam logic [1:0] CMD_SRC_READ = 2'd0;
   localparam logic [1:0] CMD_TGT_READ = 2'd1;
   localparam logic [1:0] CMD_SRC_COPY = 2'd2;
   localparam logic [1:0] CMD_TGT_COPY = 2'd3;

   localparam logic [0:0] CSR_ROM_SIZE  = 1'd0;
   localparam logic [0:0] CSR_PATCH_LEN = 1'd1;

   localparam int TRAILER_BYTES = 12;
   localparam int MIN_PATCH     = 16;

   // "BPS1"
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] r;
      unique case (idx)
         2'd0: r = 8'h42;
         2'd1: r = 8'h50;
         2'd2: r = 8'h53;
         default: r = 8'h31;
      endcase
      return r;
   endfunction

   // result record: 3+24+24+25+8+2+24+32*3 = 206 bits -> 208
   typedef struct packed {
      logic [31:0] expected_patch_crc;
      logic [31:0] expected_target_crc;
      logic [31:0] expected_source_crc;
      logic [23:0] final_size;
      logic [1:0]  error_code;
      logic [7:0]  literal;
      logic [24:0] run_length;
      logic [23:0] src_offset;
      logic [23:0] dest_offset;
      logic [2:0]  kind;
   } rsp_type;

endpackage

FILE: sv/bpsd_vlq.sv
// One step of the variable-length number decoder: adds the next 7-bit digit.
module bpsd_vlq #(
   parameter int VW = 26
) (
   input  logic [7:0]    data,
   input  logic [VW-1:0] accum,
   input  logic [2:0]    step,
   output logic          done,
   output logic          overflow,
   output logic [VW-1:0] value,
   output logic [VW-1:0] accum_next,
   output logic [2:0]    step_next
);
   localparam int SW = VW + 8;
   logic [SW-1:0] digit, sum1, sum2, limit;
   logic [5:0]    sh, sh1;

   always_comb begin
      sh    = 6'(7 * step);
      sh1   = 6'(7 * (step + 3'd1));
      limit = SW'(1) << VW;
      digit = SW'(data[6:0]) << sh;
      sum1  = SW'(accum) + digit;
      sum2  = sum1 + (SW'(1) << sh1);
      value = sum1[VW-1:0];
      done  = 1'b0;
      overflow   = 1'b0;
      accum_next = accum;
      step_next  = step;
      if (sum1 >= limit) begin
         overflow = 1'b1;
      end else if (data[7]) begin
         done       = 1'b1;
         accum_next = '0;
         step_next  = '0;
      end else if (step == 3'd6) begin
         overflow = 1'b1;
      end else begin
         step_next  = step + 3'd1;
         accum_next = sum2[VW-1:0];
         overflow   = (sum2 >= limit);
      end
   end
endmodule

FILE: sv/bps_patch_command_decoder.sv
// A result for a patch byte is registered and offered in the cycle after the byte is accepted.
// Throughput: one patch byte per cycle while no offered result is stalled; each byte goes through one decode pass
//   (number digit add, bound compares) between the request and result registers.
// Reset: synchronous, active high; the decoder returns to magic check, clears
//   all counters, cursors and state registers, and drops any pending result (the result data register is not cleared).
module bps_patch_command_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] patch_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [207:0] rsp_tdata,   // kind, dest_offset, src_offset, run_length, literal,
                                     // error_code, final_size, source/target/patch crc, pad
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   localparam int VW = bpsd_pkg::ADDR_BITS + 2;
   localparam int AW = bpsd_pkg::ADDR_BITS;
   localparam int CW = bpsd_pkg::ADDR_BITS + 4;   // signed cursor math

   // config and state
   logic [23:0] rom_size_ff, patch_len_ff;
   bpsd_pkg::phase_type phase_ff, phase_in;
   logic [23:0] pos_ff, pos_in;
   logic [VW-1:0] accum_ff, accum_in;
   logic [2:0]  step_ff, step_in;
   logic [AW-1:0] tsize_ff, tsize_in;
   logic [AW-1:0] meta_ff, meta_in;
   logic [23:0] wofs_ff, wofs_in;
   logic [VW-1:0] scur_ff, scur_in, tcur_ff, tcur_in;
   logic [1:0]  pcmd_ff, pcmd_in;
   logic [24:0] plen_ff, plen_in;
   logic [31:0] tw0_ff, tw1_ff, tw2_ff, tw0_in, tw1_in, tw2_in;
   logic        mism_ff, mism_in;

   logic        rv_ff;
   bpsd_pkg::rsp_type rsp_ff, rsp_in;
   logic        emit;

   logic vdone, vovf;
   logic [VW-1:0] vval, vacc_n;
   logic [2:0]    vstep_n;

   bpsd_vlq #(.VW(VW)) u_vlq (
      .data(req_tdata), .accum(accum_ff), .step(step_ff),
      .done(vdone), .overflow(vovf), .value(vval),
      .accum_next(vacc_n), .step_next(vstep_n)
   );

   logic accept;
   assign req_tready = !rv_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};

   // decode one byte
   logic [23:0] tstart, tpos;
   logic [3:0]  tsel;
   logic [VW:0]   len;
   logic [CW-1:0] mag, cur, ends;
   logic [VW+1:0] wsum;
   logic [24:0] room;
   logic        big;
   bpsd_pkg::phase_type ph;

   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; accum_in = accum_ff; step_in = step_ff;
      tsize_in = tsize_ff; meta_in = meta_ff; wofs_in = wofs_ff;
      scur_in = scur_ff; tcur_in = tcur_ff; pcmd_in = pcmd_ff; plen_in = plen_ff;
      tw0_in = tw0_ff; tw1_in = tw1_ff; tw2_in = tw2_ff; mism_in = mism_ff;
      rsp_in = '0; emit = 1'b0;
      tstart = patch_len_ff - 24'(bpsd_pkg::TRAILER_BYTES);
      tpos = pos_ff - tstart;
      tsel = '0;
      len  = (VW+1)'(vval >> 2) + (VW+1)'(1);
      wsum = (VW+2)'(wofs_ff) + (VW+2)'(len);
      room = 25'(tstart) - 25'(pos_ff) - 25'd1;
      mag  = CW'(vval >> 1);
      cur  = '0; ends = '0;
      big  = (vval >> AW) != '0;
      ph   = phase_ff;
      if (phase_ff == bpsd_pkg::PH_DONE || phase_ff == bpsd_pkg::PH_ERROR) begin
         ph = phase_ff;
      end else if (patch_len_ff < 24'(bpsd_pkg::MIN_PATCH)) begin
         emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
         rsp_in.error_code = bpsd_pkg::ERR_MALFORMED; phase_in = bpsd_pkg::PH_ERROR;
      end else begin
         pos_in = pos_ff + 24'd1;
         if (pos_ff >= tstart && phase_ff != bpsd_pkg::PH_TRAILER) begin
            if (phase_ff == bpsd_pkg::PH_CMD && step_ff == 3'd0) begin
               ph = bpsd_pkg::PH_TRAILER; phase_in = bpsd_pkg::PH_TRAILER;
            end else begin
               ph = bpsd_pkg::PH_ERROR; emit = 1'b1;
               rsp_in.kind = bpsd_pkg::KIND_ERROR;
               rsp_in.error_code = bpsd_pkg::ERR_MALFORMED; phase_in = bpsd_pkg::PH_ERROR;
            end
         end
         unique case (ph)
            bpsd_pkg::PH_ERROR: ;
            bpsd_pkg::PH_MAGIC: begin
               if (req_tdata != bpsd_pkg::magic_byte(pos_ff[1:0])) begin
                  emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
                  rsp_in.error_code = bpsd_pkg::ERR_MALFORMED; phase_in = bpsd_pkg::PH_ERROR;
               end else if (pos_ff >= 24'd3) phase_in = bpsd_pkg::PH_SRC;
            end
            bpsd_pkg::PH_META: begin
               meta_in = meta_ff - AW'(1);
               if (meta_in == '0) begin
                  if (mism_ff) begin
                     emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
                     rsp_in.error_code = bpsd_pkg::ERR_SIZE; phase_in = bpsd_pkg::PH_ERROR;
                  end else phase_in = bpsd_pkg::PH_CMD;
               end
            end
            bpsd_pkg::PH_LIT: begin
               emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_LITERAL;
               rsp_in.dest_offset = wofs_ff; rsp_in.run_length = 25'd1;
               rsp_in.literal = req_tdata;
               wofs_in = wofs_ff + 24'd1;
               plen_in = plen_ff - 25'd1;
               if (plen_in == '0) phase_in = bpsd_pkg::PH_CMD;
            end
            bpsd_pkg::PH_TRAILER: begin
               // bytes past the last trailer slot all land in its top byte
               tsel = (tpos > 24'd11) ? 4'd11 : tpos[3:0];
               unique case (tsel[3:2])
                  2'd0: tw0_in = tw0_ff | (32'(req_tdata) << {tsel[1:0], 3'b000});
                  2'd1: tw1_in = tw1_ff | (32'(req_tdata) << {tsel[1:0], 3'b000});
                  default: tw2_in = tw2_ff | (32'(req_tdata) << {tsel[1:0], 3'b000});
               endcase
               if (tsel == 4'd11) begin
                  emit = 1'b1; phase_in = bpsd_pkg::PH_DONE;
                  rsp_in.kind = bpsd_pkg::KIND_DONE;
                  rsp_in.final_size = 24'(tsize_ff);
                  rsp_in.expected_source_crc = tw0_in;
                  rsp_in.expected_target_crc = tw1_in;
                  rsp_in.expected_patch_crc  = tw2_in;
               end
            end
            bpsd_pkg::PH_SRC, bpsd_pkg::PH_TGT, bpsd_pkg::PH_METALEN,
            bpsd_pkg::PH_CMD, bpsd_pkg::PH_OFS: begin
               accum_in = vacc_n; step_in = vstep_n;
               if (vovf) begin
                  emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
                  rsp_in.error_code = bpsd_pkg::ERR_MALFORMED; phase_in = bpsd_pkg::PH_ERROR;
               end else if (vdone) begin
                  unique case (ph)
                     bpsd_pkg::PH_SRC: begin
                        if (big) begin
                           emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
                           rsp_in.error_code = bpsd_pkg::ERR_MALFORMED;
                           phase_in = bpsd_pkg::PH_ERROR;
                        end else begin
                           mism_in = (vval != VW'(rom_size_ff));
                           phase_in = bpsd_pkg::PH_TGT;
                        end
                     end
                     bpsd_pkg::PH_TGT: begin
                        if (big) begin
                           emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
                           rsp_in.error_code = bpsd_pkg::ERR_MALFORMED;
                           phase_in = bpsd_pkg::PH_ERROR;
                        end else begin
                           tsize_in = vval[AW-1:0]; phase_in = bpsd_pkg::PH_METALEN;
                        end
                     end
                     bpsd_pkg::PH_METALEN: begin
                        if (big) begin
                           emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
                           rsp_in.error_code = bpsd_pkg::ERR_MALFORMED;
                           phase_in = bpsd_pkg::PH_ERROR;
                        end else if (vval == '0) begin
                           if (mism_ff) begin
                              emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
                              rsp_in.error_code = bpsd_pkg::ERR_SIZE;
                              phase_in = bpsd_pkg::PH_ERROR;
                           end else phase_in = bpsd_pkg::PH_CMD;
                        end else begin
                           meta_in = vval[AW-1:0]; phase_in = bpsd_pkg::PH_META;
                        end
                     end
                     bpsd_pkg::PH_CMD: begin
                        if (wsum > (VW+2)'(tsize_ff)) begin
                           emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
                           rsp_in.error_code = bpsd_pkg::ERR_RANGE;
                           phase_in = bpsd_pkg::PH_ERROR;
                        end else begin
                           unique case (vval[1:0])
                              bpsd_pkg::CMD_SRC_READ: begin
                                 emit = 1'b1;
                                 if (wsum > (VW+2)'(rom_size_ff)) begin
                                    rsp_in.kind = bpsd_pkg::KIND_ERROR;
                                    rsp_in.error_code = bpsd_pkg::ERR_RANGE;
                                    phase_in = bpsd_pkg::PH_ERROR;
                                 end else begin
                                    rsp_in.kind = bpsd_pkg::KIND_SRC_READ;
                                    rsp_in.dest_offset = wofs_ff;
                                    rsp_in.src_offset  = wofs_ff;
                                    rsp_in.run_length  = 25'(len);
                                    wofs_in = 24'(wsum);
                                 end
                              end
                              bpsd_pkg::CMD_TGT_READ: begin
                                 if (len > (VW+1)'(room)) begin
                                    emit = 1'b1; rsp_in.kind = bpsd_pkg::KIND_ERROR;
                                    rsp_in.error_code = bpsd_pkg::ERR_MALFORMED;
                                    phase_in = bpsd_pkg::PH_ERROR;
                                 end else begin
                                    plen_in = 25'(len); phase_in = bpsd_pkg::PH_LIT;
                                 end
                              end
                              default: begin
                                 pcmd_in = vval[1:0]; plen_in = 25'(len);
                                 phase_in = bpsd_pkg::PH_OFS;
                              end
                           endcase
                        end
                     end
                     default: begin
                        // offset number: signed delta applied to the chosen cursor
                        cur = (pcmd_ff == bpsd_pkg::CMD_SRC_COPY) ? CW'(scur_ff) : CW'(tcur_ff);
                        cur = vval[0] ? cur - mag : cur + mag;
                        ends = cur + CW'(plen_ff);
                        emit = 1'b1;
                        if (cur[CW-1] ||
                            ((pcmd_ff == bpsd_pkg::CMD_SRC_COPY) ? (ends > CW'(rom_size_ff))
                                                                 : (cur >= CW'(wofs_ff)))) begin
                           rsp_in.kind = bpsd_pkg::KIND_ERROR;
                           rsp_in.error_code = bpsd_pkg::ERR_RANGE;
                           phase_in = bpsd_pkg::PH_ERROR;
                        end else begin
                           rsp_in.kind = (pcmd_ff == bpsd_pkg::CMD_SRC_COPY) ?
                                         bpsd_pkg::KIND_SRC_COPY : bpsd_pkg::KIND_TGT_COPY;
                           rsp_in.dest_offset = wofs_ff;
                           rsp_in.src_offset  = 24'(cur);
                           rsp_in.run_length  = plen_ff;
                           if (pcmd_ff == bpsd_pkg::CMD_SRC_COPY) scur_in = VW'(ends);
                           else tcur_in = VW'(ends);
                           wofs_in = wofs_ff + 24'(plen_ff);
                           phase_in = bpsd_pkg::PH_CMD;
                        end
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rom_size_ff <= '0; patch_len_ff <= '0;
         phase_ff <= bpsd_pkg::PH_MAGIC; pos_ff <= '0; accum_ff <= '0; step_ff <= '0;
         tsize_ff <= '0; meta_ff <= '0; wofs_ff <= '0; scur_ff <= '0; tcur_ff <= '0;
         pcmd_ff <= '0; plen_ff <= '0; tw0_ff <= '0; tw1_ff <= '0; tw2_ff <= '0;
         mism_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == bpsd_pkg::CSR_ROM_SIZE) rom_size_ff <= csr_wdata;
            else patch_len_ff <= csr_wdata;
         end
         // a new result replaces the one taken in the same cycle
         if (accept && emit) rv_ff <= 1'b1;
         else if (rsp_tready) rv_ff <= 1'b0;
         if (accept) begin
            phase_ff <= phase_in; pos_ff <= pos_in; accum_ff <= accum_in; step_ff <= step_in;
            tsize_ff <= tsize_in; meta_ff <= meta_in; wofs_ff <= wofs_in;
            scur_ff <= scur_in; tcur_ff <= tcur_in; pcmd_ff <= pcmd_in; plen_ff <= plen_in;
            tw0_ff <= tw0_in; tw1_ff <= tw1_in; tw2_ff <= tw2_in; mism_ff <= mism_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_sticky_error: assert property (@(posedge clock) disable iff (reset)
      phase_ff == bpsd_pkg::PH_ERROR |=> phase_ff == bpsd_pkg::PH_ERROR)
      else $error("error phase left");
   a_err_emits: assert property (@(posedge clock) disable iff (reset)
      accept && phase_in == bpsd_pkg::PH_ERROR && phase_ff != bpsd_pkg::PH_ERROR |-> emit)
      else $error("error without result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_tready |=> rv_ff && $stable(rsp_ff))
      else $error("result lost under stall");
   a_no_emit_end: assert property (@(posedge clock) disable iff (reset)
      phase_ff == bpsd_pkg::PH_DONE |-> !emit)
      else $error("result after done");
`endif
endmodule

FILE: tb/sv/bps_patch_command_decoder_tb.sv
`timescale 1ns / 100ps

module bps_patch_command_decoder_tb;

   localparam longint unsigned NUM_LIMIT = 64'd1 << 26;
   localparam longint unsigned ADDR_MAX  = 64'hff_ffff;
   localparam int CYCLE_LIMIT = 300000;
   localparam logic [7:0] MAGIC [4] = '{8'h42, 8'h50, 8'h53, 8'h31};

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [207:0] rsp_tdata;
   logic         csr_we;
   logic [0:0]   csr_index;
   logic [23:0]  csr_wdata;

   bps_patch_command_decoder DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // pending patch bytes and expected results
   logic [7:0] patch_bytes [$];
   bpsd_pkg::rsp_type expected_cmds [$];
   int         fail_count = 0;
   int         req_count = 0;
   int         cycle_count = 0;
   int         hold_left = 0;
   bit         hold_used = 0;
   int         kind_seen [6];

   // decoder copy of the block state
   bpsd_pkg::phase_type dec_phase = bpsd_pkg::PH_MAGIC;
   logic [23:0]     dec_pos = '0;
   longint unsigned num_acc = 0;
   int unsigned     num_step = 0;
   logic [23:0]     tgt_size = '0;
   logic [23:0]     meta_left = '0;
   logic [23:0]     wr_ofs = '0;
   longint          src_cur = 0;
   longint          tgt_cur = 0;
   logic [1:0]      pend_cmd = '0;
   logic [24:0]     pend_len = '0;
   logic [31:0]     crc_words [3] = '{32'd0, 32'd0, 32'd0};
   bit              size_bad = 1'b0;
   logic [23:0]     cfg_rom;
   logic [23:0]     cfg_plen;

   // patch generator state
   longint gen_wo, gen_sc, gen_tc, gen_rom, gen_tgt;
   int     gen_count;

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic set_error(input logic [1:0] code, output bit has,
                            output bpsd_pkg::rsp_type r);
      r = '0;
      r.kind = bpsd_pkg::KIND_ERROR;
      r.error_code = code;
      dec_phase = bpsd_pkg::PH_ERROR;
      has = 1'b1;
   endtask

   function automatic bpsd_pkg::rsp_type run_cmd(input bpsd_pkg::kind_type k,
                                                 input longint unsigned src,
                                                 input longint unsigned len);
      bpsd_pkg::rsp_type r;
      r = '0;
      r.kind = k;
      r.dest_offset = wr_ofs;
      r.src_offset = src[23:0];
      r.run_length = len[24:0];
      return r;
   endfunction

   // decode one patch byte; has=1 when a result is expected
   task automatic decode_patch_byte(input logic [7:0] b, output bit has,
                                    output bpsd_pkg::rsp_type r);
      logic [31:0] pos, tstart, t;
      longint unsigned v, len;
      longint mag, delta, c;
      has = 1'b0;
      r = '0;
      if (dec_phase == bpsd_pkg::PH_DONE || dec_phase == bpsd_pkg::PH_ERROR) return;
      if (cfg_plen < 24'(bpsd_pkg::MIN_PATCH)) begin
         set_error(bpsd_pkg::ERR_MALFORMED, has, r);
         return;
      end
      tstart = 32'(cfg_plen) - 32'(bpsd_pkg::TRAILER_BYTES);
      pos = 32'(dec_pos);
      dec_pos = dec_pos + 24'd1;
      // trailer reached: only legal between commands
      if (pos >= tstart && dec_phase != bpsd_pkg::PH_TRAILER) begin
         if (dec_phase == bpsd_pkg::PH_CMD && num_step == 0) dec_phase = bpsd_pkg::PH_TRAILER;
         else begin
            set_error(bpsd_pkg::ERR_MALFORMED, has, r);
            return;
         end
      end
      case (dec_phase)
         bpsd_pkg::PH_MAGIC: begin
            if (b != MAGIC[pos[1:0]]) set_error(bpsd_pkg::ERR_MALFORMED, has, r);
            else if (pos >= 3) dec_phase = bpsd_pkg::PH_SRC;
            return;
         end
         bpsd_pkg::PH_META: begin
            meta_left = meta_left - 24'd1;
            if (meta_left == 0) begin
               if (size_bad) set_error(bpsd_pkg::ERR_SIZE, has, r);
               else dec_phase = bpsd_pkg::PH_CMD;
            end
            return;
         end
         bpsd_pkg::PH_LIT: begin
            r.kind = bpsd_pkg::KIND_LITERAL;
            r.dest_offset = wr_ofs;
            r.run_length = 25'd1;
            r.literal = b;
            has = 1'b1;
            wr_ofs = wr_ofs + 24'd1;
            pend_len = pend_len - 25'd1;
            if (pend_len == 0) dec_phase = bpsd_pkg::PH_CMD;
            return;
         end
         bpsd_pkg::PH_TRAILER: begin
            t = pos - tstart;
            if (t > 11) t = 11;
            crc_words[t >> 2] = crc_words[t >> 2] | (32'(b) << (8 * t[1:0]));
            if (t == 11) begin
               dec_phase = bpsd_pkg::PH_DONE;
               r.kind = bpsd_pkg::KIND_DONE;
               r.final_size = tgt_size;
               r.expected_source_crc = crc_words[0];
               r.expected_target_crc = crc_words[1];
               r.expected_patch_crc = crc_words[2];
               has = 1'b1;
            end
            return;
         end
         default: ;
      endcase

      // variable-length number digit
      num_acc = num_acc + (64'(b & 8'h7f) << (7 * num_step));
      if (num_acc >= NUM_LIMIT) begin
         set_error(bpsd_pkg::ERR_MALFORMED, has, r);
         return;
      end
      if (!b[7]) begin
         num_step++;
         if (num_step > 6) begin
            set_error(bpsd_pkg::ERR_MALFORMED, has, r);
            return;
         end
         num_acc = num_acc + (64'd1 << (7 * num_step));
         if (num_acc >= NUM_LIMIT) set_error(bpsd_pkg::ERR_MALFORMED, has, r);
         return;
      end
      v = num_acc;
      num_acc = 0;
      num_step = 0;

      case (dec_phase)
         bpsd_pkg::PH_SRC, bpsd_pkg::PH_TGT, bpsd_pkg::PH_METALEN: begin
            if (v > ADDR_MAX) begin
               set_error(bpsd_pkg::ERR_MALFORMED, has, r);
               return;
            end
            if (dec_phase == bpsd_pkg::PH_SRC) begin
               size_bad = (v != 64'(cfg_rom));
               dec_phase = bpsd_pkg::PH_TGT;
            end else if (dec_phase == bpsd_pkg::PH_TGT) begin
               tgt_size = v[23:0];
               dec_phase = bpsd_pkg::PH_METALEN;
            end else if (v == 0) begin
               if (size_bad) set_error(bpsd_pkg::ERR_SIZE, has, r);
               else dec_phase = bpsd_pkg::PH_CMD;
            end else begin
               meta_left = v[23:0];
               dec_phase = bpsd_pkg::PH_META;
            end
         end
         bpsd_pkg::PH_CMD: begin
            len = (v >> 2) + 1;
            if (64'(wr_ofs) + len > 64'(tgt_size)) begin
               set_error(bpsd_pkg::ERR_RANGE, has, r);
               return;
            end
            case (v[1:0])
               bpsd_pkg::CMD_SRC_READ: begin
                  if (64'(wr_ofs) + len > 64'(cfg_rom)) begin
                     set_error(bpsd_pkg::ERR_RANGE, has, r);
                     return;
                  end
                  r = run_cmd(bpsd_pkg::KIND_SRC_READ, 64'(wr_ofs), len);
                  has = 1'b1;
                  wr_ofs = wr_ofs + len[23:0];
               end
               bpsd_pkg::CMD_TGT_READ: begin
                  if (len > 64'(tstart - pos - 1)) begin
                     set_error(bpsd_pkg::ERR_MALFORMED, has, r);
                     return;
                  end
                  pend_len = len[24:0];
                  dec_phase = bpsd_pkg::PH_LIT;
               end
               default: begin
                  pend_cmd = v[1:0];
                  pend_len = len[24:0];
                  dec_phase = bpsd_pkg::PH_OFS;
               end
            endcase
         end
         bpsd_pkg::PH_OFS: begin
            mag = longint'(v >> 1);
            delta = v[0] ? -mag : mag;
            len = 64'(pend_len);
            if (pend_cmd == bpsd_pkg::CMD_SRC_COPY) begin
               c = src_cur + delta;
               if (c < 0 || c + longint'(len) > longint'(cfg_rom)) begin
                  set_error(bpsd_pkg::ERR_RANGE, has, r);
                  return;
               end
               r = run_cmd(bpsd_pkg::KIND_SRC_COPY, c, len);
               src_cur = c + longint'(len);
            end else begin
               c = tgt_cur + delta;
               if (c < 0 || c >= longint'(wr_ofs)) begin
                  set_error(bpsd_pkg::ERR_RANGE, has, r);
                  return;
               end
               r = run_cmd(bpsd_pkg::KIND_TGT_COPY, c, len);
               tgt_cur = c + longint'(len);
            end
            has = 1'b1;
            wr_ofs = wr_ofs + len[23:0];
            dec_phase = bpsd_pkg::PH_CMD;
         end
         default: set_error(bpsd_pkg::ERR_MALFORMED, has, r);
      endcase
   endtask

   // idle percentages per stage of the run
   function automatic int tx_idle_pct();
      return (req_count < 230) ? 37 : (req_count < 460) ? 65 : 0;
   endfunction

   function automatic int rx_idle_pct();
      return (req_count < 230) ? 65 : (req_count < 460) ? 37 : 0;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (patch_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
            req_tvalid <= 1'b1;
            req_tdata <= patch_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off once the stream is well under way
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_used && req_count >= 330) begin
         hold_used <= 1'b1;
         hold_left <= 400;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result receiver
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= (hold_left <= 1) && ($urandom_range(0, 99) >= rx_idle_pct());
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      bit has;
      bpsd_pkg::rsp_type want, got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = bpsd_pkg::rsp_type'(rsp_tdata[205:0]);
            if (rsp_tdata[207:206] != 0) report("pad", 64'(rsp_tdata[207:206]), 0);
            if (expected_cmds.size() == 0) begin
               report("unexpected result kind", 64'(got.kind), 0);
            end else begin
               want = expected_cmds.pop_front();
               if (got.kind <= bpsd_pkg::KIND_ERROR) kind_seen[got.kind]++;
               if (got.kind != want.kind) report("kind", got.kind, want.kind);
               if (got.dest_offset != want.dest_offset)
                  report("dest_offset", got.dest_offset, want.dest_offset);
               if (got.src_offset != want.src_offset)
                  report("src_offset", got.src_offset, want.src_offset);
               if (got.run_length != want.run_length)
                  report("run_length", got.run_length, want.run_length);
               if (got.literal != want.literal) report("literal", got.literal, want.literal);
               if (got.error_code != want.error_code)
                  report("error_code", got.error_code, want.error_code);
               if (got.final_size != want.final_size)
                  report("final_size", got.final_size, want.final_size);
               if (got.expected_source_crc != want.expected_source_crc)
                  report("source_crc", got.expected_source_crc, want.expected_source_crc);
               if (got.expected_target_crc != want.expected_target_crc)
                  report("target_crc", got.expected_target_crc, want.expected_target_crc);
               if (got.expected_patch_crc != want.expected_patch_crc)
                  report("patch_crc", got.expected_patch_crc, want.expected_patch_crc);
            end
         end
         if (req_tvalid && req_tready) begin
            req_count <= req_count + 1;
            decode_patch_byte(req_tdata, has, want);
            if (has) expected_cmds.push_back(want);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      patch_bytes.push_back(b);
      gen_count++;
   endtask

   // variable-length number encoding
   task automatic push_num(input longint unsigned v);
      while (1) begin
         if ((v >> 7) == 0) begin
            push_byte(8'h80 | {1'b0, v[6:0]});
            break;
         end
         push_byte({1'b0, v[6:0]});
         v = (v >> 7) - 1;
      end
   endtask

   task automatic push_offset(input longint d);
      push_num(d < 0 ? ((longint'(-d) << 1) | 1) : (longint'(d) << 1));
   endtask

   // one well-formed command
   task automatic gen_cmd(input logic [1:0] op, input int unsigned len);
      longint c;
      push_num((longint'(len - 1) << 2) | longint'(op));
      case (op)
         bpsd_pkg::CMD_TGT_READ: repeat (len) push_byte(8'($urandom_range(0, 255)));
         bpsd_pkg::CMD_SRC_COPY: begin
            c = $urandom_range(0, 32'(gen_rom - len));
            push_offset(c - gen_sc);
            gen_sc = c + len;
         end
         bpsd_pkg::CMD_TGT_COPY: begin
            c = $urandom_range(0, 32'(gen_wo - 1));
            push_offset(c - gen_tc);
            gen_tc = c + len;
         end
         default: ;
      endcase
      gen_wo += len;
   endtask

   task automatic gen_random_cmd();
      logic [1:0] op;
      int unsigned len;
      op = 2'($urandom_range(0, 3));
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 4000) : $urandom_range(1, 8);
      if (op == bpsd_pkg::CMD_TGT_READ) len = $urandom_range(1, 6);
      if (op == bpsd_pkg::CMD_TGT_COPY && gen_wo == 0) op = bpsd_pkg::CMD_TGT_READ;
      if (gen_wo + len > gen_tgt || (op == bpsd_pkg::CMD_SRC_READ && gen_wo + len > gen_rom)
          || (op == bpsd_pkg::CMD_SRC_COPY && len > gen_rom)) begin
         op = bpsd_pkg::CMD_TGT_READ;
         len = 1;
      end
      gen_cmd(op, len);
   endtask

   // register write while the decoder is idle
   task automatic csr_write(input logic [0:0] idx, input logic [23:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == bpsd_pkg::CSR_ROM_SIZE) cfg_rom = value;
      else cfg_plen = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (patch_bytes.size() != 0 || req_tvalid || expected_cmds.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // stimulus
   initial begin
      bit end_in_error;
      int unsigned meta_len;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_rom = 0; cfg_plen = 0;
      gen_wo = 0; gen_sc = 0; gen_tc = 0; gen_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      gen_rom = $urandom_range(0, 1) ? 64'hff_ffff : $urandom_range(1 << 20, 24'hff_ffff);
      gen_tgt = 24'hff_ffff;
      csr_write(bpsd_pkg::CSR_ROM_SIZE, 24'(gen_rom));
      csr_write(bpsd_pkg::CSR_PATCH_LEN, 24'hff_ffff);

      // header: magic, sizes, metadata
      for (int i = 0; i < 4; i++) push_byte(MAGIC[i]);
      push_num(gen_rom);
      push_num(gen_tgt);
      meta_len = $urandom_range(0, 3);
      push_num(64'(meta_len));
      repeat (meta_len) push_byte(8'($urandom_range(0, 255)));

      // directed: each command, literal extremes
      push_num((longint'(1) << 2) | longint'(bpsd_pkg::CMD_TGT_READ));
      push_byte(8'h00);
      push_byte(8'hff);
      gen_wo += 2;
      gen_cmd(bpsd_pkg::CMD_SRC_READ, 3);
      gen_cmd(bpsd_pkg::CMD_SRC_COPY, 2);
      gen_cmd(bpsd_pkg::CMD_TGT_COPY, 1);
      gen_cmd(bpsd_pkg::CMD_SRC_COPY, 1);
      gen_cmd(bpsd_pkg::CMD_TGT_COPY, 4);

      // random commands, with a rom size change part way through
      while (gen_count < 320) gen_random_cmd();
      drain();
      gen_rom = (gen_rom == 64'hff_ffff) ? (1 << 20) : 64'hff_ffff;
      csr_write(bpsd_pkg::CSR_ROM_SIZE, 24'(gen_rom));
      while (gen_count < 640) gen_random_cmd();

      end_in_error = ($urandom_range(0, 2) == 0);
      if (end_in_error) begin
         // target copy from the current write position is out of bounds
         push_num(64'(bpsd_pkg::CMD_TGT_COPY));
         push_offset(gen_wo - gen_tc);
         repeat (4) push_byte(8'($urandom_range(0, 255)));
         drain();
      end else begin
         drain();
         csr_write(bpsd_pkg::CSR_PATCH_LEN, 24'(gen_count + bpsd_pkg::TRAILER_BYTES));
         repeat (bpsd_pkg::TRAILER_BYTES) push_byte(8'($urandom_range(0, 255)));
         drain();
      end

      // after the stream ends nothing more comes out
      csr_write(bpsd_pkg::CSR_ROM_SIZE, 24'd0);
      csr_write(bpsd_pkg::CSR_PATCH_LEN, 24'd0);
      repeat (5) push_byte(8'($urandom_range(0, 255)));
      drain();
      repeat (10) @(posedge clock);

      $display("Decoded %0d patch bytes ending in %s.", req_count,
               end_in_error ? "a bounds error" : "the trailer");
      $display("Results: %0d literal, %0d src read, %0d src copy, %0d tgt copy,",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("         %0d done, %0d error", kind_seen[4], kind_seen[5]);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
